// ----- design/sorted_key_table_search_defines.svh -----
// Assertion macros for the sorted key table search block
`ifndef SORTED_KEY_TABLE_SEARCH_DEFINES_SVH
`define SORTED_KEY_TABLE_SEARCH_DEFINES_SVH
// assert a property on the rising clock edge, off during reset
`define SKTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// assert a property that must also hold while reset is applied
`define SKTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ----- design/skts_pkg.sv -----
// Package: sizes, opcodes and status codes of the sorted key table search block
`default_nettype none
package skts_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned KeyBytes   = 8;
  localparam int unsigned TagWidth   = 16;
  localparam int unsigned KeyW       = 8 * KeyBytes;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned PosW       = 6;

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpSort   = 2'd2;
  localparam logic [1:0] OpLookup = 2'd3;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [TagWidth-1:0] tag;
  } rec_t;
endpackage
`default_nettype wire

// ----- design/skts_if.sv -----
// Interfaces: command and result channels with valid/ready handshake
`default_nettype none
interface skts_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] search_key;
  logic [15:0] record_tag;
  modport source (output valid, opcode, search_key, record_tag, input ready);
  modport sink (input valid, opcode, search_key, record_tag, output ready);
endinterface

interface skts_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  position;
  logic [15:0] found_tag;
  modport source (output valid, status, position, found_tag, input ready);
  modport sink (input valid, status, position, found_tag, output ready);
endinterface
`default_nettype wire

// ----- design/skts_ram.sv -----
// Single-port-write, single-read synchronous record memory
`default_nettype none
module skts_ram
  import skts_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire rec_t             wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output rec_t                  rdata_o
);
  rec_t mem [TableDepth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/skts_ctrl.sv -----
// Sequencer: clear, append, insertion sort and binary search over the record memory
`default_nettype none
`include "sorted_key_table_search_defines.svh"
module skts_ctrl
  import skts_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  skts_cmd_if.sink              cmd,
  skts_rsp_if.source            rsp,
  output logic                  we_o,
  output logic [AddrW-1:0]      waddr_o,
  output rec_t                  wdata_o,
  output logic [AddrW-1:0]      raddr_o,
  input  wire rec_t             rdata_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_SI_RD, S_SI_WT, S_SJ_RD, S_SJ_WT, S_SJ_CMP, S_LK_RD, S_LK_WT, S_LK_CMP, S_OUT
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  i_q, j_q;
  rec_t             cur_q;
  logic [KeyW-1:0]  key_q;
  logic signed [CntW:0] lo_q, hi_q;
  logic [AddrW-1:0] mid_q;
  logic [1:0]       st_q;
  logic [PosW-1:0]  pos_q;
  logic [TagWidth-1:0] ftag_q;
  logic             rvalid_q;

  logic signed [CntW+1:0] sum;
  assign sum = {lo_q[CntW], lo_q} + {hi_q[CntW], hi_q};

  assign cmd.ready = (state_q == S_IDLE) && !rvalid_q;
  assign rsp.valid = rvalid_q;
  assign rsp.status = st_q;
  assign rsp.position = pos_q;
  assign rsp.found_tag = ftag_q;

  always_comb begin
    we_o = 1'b0;
    waddr_o = count_q[AddrW-1:0];
    wdata_o = '{key: cmd.search_key[KeyW-1:0], tag: cmd.record_tag[TagWidth-1:0]};
    raddr_o = i_q[AddrW-1:0];
    case (state_q)
      S_IDLE: begin
        we_o = cmd.valid && cmd.ready && cmd.opcode == OpAppend && count_q < CntW'(TableDepth);
      end
      S_SJ_RD, S_SJ_WT: raddr_o = AddrW'(j_q - 1'b1);
      S_SJ_CMP: begin
        we_o = 1'b1;
        waddr_o = j_q[AddrW-1:0];
        wdata_o = (j_q != '0 && rdata_i.key > cur_q.key) ? rdata_i : cur_q;
      end
      S_LK_RD: raddr_o = mid_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rvalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (cmd.valid && cmd.ready) begin
          st_q <= StOk; pos_q <= '0; ftag_q <= '0;
          key_q <= cmd.search_key[KeyW-1:0];
          case (cmd.opcode)
            OpClear: begin count_q <= '0; state_q <= S_OUT; end
            OpAppend: begin
              if (count_q < CntW'(TableDepth)) count_q <= count_q + 1'b1;
              else st_q <= StFull;
              state_q <= S_OUT;
            end
            OpSort: begin i_q <= CntW'(1); state_q <= S_SI_RD; end
            default: begin
              lo_q <= '0;
              hi_q <= (CntW+1)'($signed({1'b0, count_q}) - 1);
              state_q <= S_LK_CMP;
            end
          endcase
        end
        S_SI_RD: begin
          if (i_q >= count_q) state_q <= S_OUT;
          else state_q <= S_SI_WT;
        end
        S_SI_WT: begin j_q <= i_q; state_q <= S_SJ_RD; end
        S_SJ_RD: begin
          if (j_q == '0) state_q <= S_SJ_CMP;
          else state_q <= S_SJ_WT;
        end
        S_SJ_WT: state_q <= S_SJ_CMP;
        S_SJ_CMP: begin
          if (j_q != '0 && rdata_i.key > cur_q.key) begin
            j_q <= j_q - 1'b1; state_q <= S_SJ_RD;
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_SI_RD;
          end
        end
        S_LK_CMP: begin
          if (lo_q > hi_q) begin st_q <= StMiss; state_q <= S_OUT; end
          else begin mid_q <= AddrW'(sum >>> 1); state_q <= S_LK_RD; end
        end
        S_LK_RD: state_q <= S_LK_WT;
        S_LK_WT: begin
          if (rdata_i.key == key_q) begin
            pos_q <= PosW'(mid_q); ftag_q <= rdata_i.tag; state_q <= S_OUT;
          end else if (rdata_i.key < key_q) begin
            lo_q <= (CntW+1)'($signed({2'b0, mid_q}) + 1); state_q <= S_LK_CMP;
          end else begin
            hi_q <= (CntW+1)'($signed({2'b0, mid_q}) - 1); state_q <= S_LK_CMP;
          end
        end
        S_OUT: begin rvalid_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_SI_WT) cur_q <= rdata_i;
    end
  end

  // S_SJ_CMP with j==0 reads stale data; guarded by j_q check, writes cur_q
  `SKTS_ASSERT(a_cnt_max, count_q <= CntW'(TableDepth), "entry count overflow")
  `SKTS_ASSERT(a_no_accept_busy, (state_q != S_IDLE) |-> !cmd.ready, "accept while busy")
  `SKTS_ASSERT(a_rsp_hold, (rsp.valid && !rsp.ready) |=> rsp.valid, "result dropped")
endmodule
`default_nettype wire

// ----- design/sorted_key_table_search.sv -----
// Top level: sorted key table search block
// Records (key, tag) live in one 64-entry synchronous memory. A lookup is a binary search
// with at most 7 probes for 64 entries; a sort is an in-place stable insertion sort whose
// record shifts all go through the single memory read port. One command at a time; result
// held in an output register until taken.
`default_nettype none
module sorted_key_table_search
  import skts_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  skts_cmd_if.sink   cmd,
  skts_rsp_if.source rsp
);
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  rec_t             wdata, rdata;

  skts_ctrl u_ctrl (
    .clk_i, .rst_ni, .cmd, .rsp,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  skts_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
endmodule
`default_nettype wire
